// File: sv/susi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package susi_pkg;

    // Set size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 16;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // Micro-program counter
    typedef logic [3:0] upc_t;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_TRUE,
        COND_IN_FIRE,
        COND_IDX_EQ_CNT,
        COND_GE,
        COND_EQ,
        COND_FULL,
        COND_IDX_EQ_POS,
        COND_OUT_FIRE
    } cond_t;

    // Read address source
    typedef enum logic {
        RA_IDX,
        RA_IDX_M1
    } ra_sel_t;

    // Write address and data sources
    typedef enum logic {
        WA_IDX,
        WA_POS
    } wa_sel_t;

    typedef enum logic {
        WD_RDATA,
        WD_VALUE
    } wd_sel_t;

    // Index register operations
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_CNT
    } idx_op_t;

    // Match flag operations
    typedef enum logic [1:0] {
        EQ_HOLD,
        EQ_CLR,
        EQ_CMP
    } eq_op_t;

    // One control word of the micro-program
    typedef struct packed {
        logic    in_ready;
        logic    out_valid;
        logic    val_ld;
        cond_t   cond;
        upc_t    next_t;
        upc_t    next_f;
        ra_sel_t ra;
        logic    we;
        wa_sel_t wa;
        wd_sel_t wd;
        idx_op_t idx_op;
        logic    pos_ld;
        eq_op_t  eq_op;
        logic    st_ld;
        status_t st;
        logic    cnt_inc;
    } uword_t;

endpackage

`default_nettype wire

// File: sv/sorted_unique_set_insert_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted set of unique signed 32-bit values, up to CAPACITY entries, held in
// ascending order in a single-read-port RAM. Each input beat carries one value
// and gives one output beat: status (inserted, already present, set full),
// the sorted position of the value (the count when full) and the new count.
// Items are handled one at a time by a micro-programmed sequencer. The scan
// reads one entry at a time until it reaches the first entry not below the
// value or the end of the set; an insert then moves each larger entry up one
// place through the same RAM port. A duplicate ends right after the scan.
// Stored values need no clearing after reset.

module sorted_unique_set_insert_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [1:0] status, [6:2] position, [11:7] count
);

    import susi_pkg::*;

    // Step addresses of the micro-program
    localparam upc_t U_IDLE   = 4'd0;
    localparam upc_t U_SCAN   = 4'd1;
    localparam upc_t U_CMP    = 4'd2;
    localparam upc_t U_DUP    = 4'd3;
    localparam upc_t U_FULL   = 4'd4;
    localparam upc_t U_SHTEST = 4'd5;
    localparam upc_t U_SHWR   = 4'd6;
    localparam upc_t U_INSERT = 4'd7;
    localparam upc_t U_FPOS   = 4'd8;
    localparam upc_t U_OUT    = 4'd9;

    localparam uword_t UWORD_NOP = '{
        in_ready:  1'b0,
        out_valid: 1'b0,
        val_ld:    1'b0,
        cond:      COND_TRUE,
        next_t:    U_IDLE,
        next_f:    U_IDLE,
        ra:        RA_IDX,
        we:        1'b0,
        wa:        WA_IDX,
        wd:        WD_RDATA,
        idx_op:    IDX_HOLD,
        pos_ld:    1'b0,
        eq_op:     EQ_HOLD,
        st_ld:     1'b0,
        st:        ST_INSERTED,
        cnt_inc:   1'b0
    };

    // Control store
    function automatic uword_t ucode(input upc_t a);
        uword_t w;
        w = UWORD_NOP;
        unique case (a)
            U_IDLE:
            begin
                w.in_ready = 1'b1;
                w.val_ld   = 1'b1;
                w.idx_op   = IDX_ZERO;
                w.eq_op    = EQ_CLR;
                w.cond     = COND_IN_FIRE;
                w.next_t   = U_SCAN;
                w.next_f   = U_IDLE;
            end
            U_SCAN:
            begin
                w.ra     = RA_IDX;
                w.pos_ld = 1'b1;
                w.cond   = COND_IDX_EQ_CNT;
                w.next_t = U_DUP;
                w.next_f = U_CMP;
            end
            U_CMP:
            begin
                w.eq_op  = EQ_CMP;
                w.idx_op = IDX_INC;
                w.cond   = COND_GE;
                w.next_t = U_DUP;
                w.next_f = U_SCAN;
            end
            U_DUP:
            begin
                w.st_ld  = 1'b1;
                w.st     = ST_PRESENT;
                w.cond   = COND_EQ;
                w.next_t = U_OUT;
                w.next_f = U_FULL;
            end
            U_FULL:
            begin
                w.st_ld  = 1'b1;
                w.st     = ST_FULL;
                w.idx_op = IDX_CNT;
                w.cond   = COND_FULL;
                w.next_t = U_FPOS;
                w.next_f = U_SHTEST;
            end
            U_SHTEST:
            begin
                w.ra     = RA_IDX_M1;
                w.cond   = COND_IDX_EQ_POS;
                w.next_t = U_INSERT;
                w.next_f = U_SHWR;
            end
            U_SHWR:
            begin
                w.we     = 1'b1;
                w.wa     = WA_IDX;
                w.wd     = WD_RDATA;
                w.idx_op = IDX_DEC;
                w.next_t = U_SHTEST;
            end
            U_INSERT:
            begin
                w.we      = 1'b1;
                w.wa      = WA_POS;
                w.wd      = WD_VALUE;
                w.cnt_inc = 1'b1;
                w.st_ld   = 1'b1;
                w.st      = ST_INSERTED;
                w.next_t  = U_OUT;
            end
            U_FPOS:
            begin
                w.pos_ld = 1'b1;
                w.next_t = U_OUT;
            end
            U_OUT:
            begin
                w.out_valid = 1'b1;
                w.cond      = COND_OUT_FIRE;
                w.next_t    = U_IDLE;
                w.next_f    = U_OUT;
            end
            default:
            begin
                w = UWORD_NOP;
            end
        endcase
        return w;
    endfunction

    upc_t                upc_reg, upc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                eq_reg, eq_next;
    status_t             st_reg, st_next;
    logic [VALUE_W-1:0]  val_reg, val_next;

    uword_t              uw;
    logic                cond_hit;
    logic                in_fire;
    logic                out_fire;
    logic [CNT_W-1:0]    idx_m1;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    // Decode the current step
    assign uw       = ucode(upc_reg);
    assign in_fire  = uw.in_ready & s_tvalid;
    assign out_fire = uw.out_valid & m_tready;
    assign idx_m1   = idx_reg - 1'b1;

    // Evaluate the branch condition
    always_comb
    begin
        unique case (uw.cond)
            COND_TRUE:       cond_hit = 1'b1;
            COND_IN_FIRE:    cond_hit = in_fire;
            COND_IDX_EQ_CNT: cond_hit = (idx_reg == cnt_reg);
            COND_GE:         cond_hit = ($signed(ram_rdata) >= $signed(val_reg));
            COND_EQ:         cond_hit = eq_reg;
            COND_FULL:       cond_hit = (cnt_reg == CNT_W'(CAPACITY));
            COND_IDX_EQ_POS: cond_hit = (idx_reg == pos_reg);
            COND_OUT_FIRE:   cond_hit = out_fire;
            default:         cond_hit = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        upc_next = cond_hit ? uw.next_t : uw.next_f;
        val_next = (uw.val_ld && in_fire) ? s_tdata : val_reg;
        cnt_next = uw.cnt_inc ? cnt_reg + 1'b1 : cnt_reg;
        pos_next = uw.pos_ld ? idx_reg : pos_reg;
        st_next  = uw.st_ld ? uw.st : st_reg;

        unique case (uw.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + 1'b1;
            IDX_DEC:  idx_next = idx_m1;
            IDX_CNT:  idx_next = cnt_reg;
            default:  idx_next = idx_reg;
        endcase

        unique case (uw.eq_op)
            EQ_HOLD: eq_next = eq_reg;
            EQ_CLR:  eq_next = 1'b0;
            EQ_CMP:  eq_next = (ram_rdata == val_reg);
            default: eq_next = eq_reg;
        endcase
    end

    // Hold sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        eq_reg  <= eq_next;
        st_reg  <= st_next;
        val_reg <= val_next;
    end

    // Steer the RAM ports
    assign ram_we    = uw.we;
    assign ram_waddr = (uw.wa == WA_POS) ? pos_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign ram_wdata = (uw.wd == WD_VALUE) ? val_reg : ram_rdata;
    assign ram_raddr = (uw.ra == RA_IDX_M1) ? idx_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    susi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Drive the stream ports
    assign s_tready = uw.in_ready;
    assign m_tvalid = uw.out_valid;
    assign m_tdata  = {
        (OUT_W - STATUS_W - POS_W - COUNT_W)'(0),
        COUNT_W'(cnt_reg),
        POS_W'(pos_reg),
        st_reg
    };

endmodule

`default_nettype wire

// File: sv/susi_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module susi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/susi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module susi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    import susi_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [POS_W-1:0]    pos;
    logic [COUNT_W-1:0]  cnt;

    assign st  = m_tdata[STATUS_W-1:0];
    assign pos = m_tdata[STATUS_W+POS_W-1:STATUS_W];
    assign cnt = m_tdata[STATUS_W+POS_W+COUNT_W-1:STATUS_W+POS_W];

    // One item in flight: never take input while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // Status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == ST_INSERTED || st == ST_PRESENT || st == ST_FULL))
        else $error("undefined status code");

    // A stored or found value sits below the count
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CAPACITY < 32) && m_tvalid && (st == ST_INSERTED || st == ST_PRESENT)
        |-> (pos < cnt))
        else $error("position not below count");

    // Full set reports position equal to count
    a_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == ST_FULL) |-> (pos == cnt))
        else $error("full result with position not equal to count");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

endmodule

bind sorted_unique_set_insert_top susi_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
